>>> hdl/i2cts_pkg.sv
// ----------------------------------------------------------------------------
// I2C transfer sequencer package
// Shared command codes, action codes, flag positions and the structs passed
// between the top level and the decision logic.
// ----------------------------------------------------------------------------
package i2cts_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_START  = 3'd1,
    CMD_EVENT  = 3'd2,
    CMD_ERROR  = 3'd3,
    CMD_STATUS = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2
  } act_e;

  // Bit positions inside the event flags.
  localparam int unsigned FLG_SB     = 0;
  localparam int unsigned FLG_ADDR   = 1;
  localparam int unsigned FLG_BTF    = 2;
  localparam int unsigned FLG_TXE    = 3;
  localparam int unsigned FLG_RXNE   = 4;
  localparam int unsigned FLG_MASTER = 5;

  localparam logic [7:0] ERR_NOT_MASTER = 8'h80;
  localparam logic [8:0] MAX_COUNT      = 9'd256;

  typedef struct packed {
    logic [7:0] tx_pos;
    logic [7:0] rx_pos;
    logic [8:0] bytes_left;
    logic       receiving;
    logic [7:0] target_addr;
    logic [7:0] err_bits;
  } state_t;

  typedef struct packed {
    logic       drv;
    logic       drd_from_addr;
    logic       start;
    logic       stop;
    act_e       ack;
    logic       pos;
    act_e       buf_irq;
    act_e       evt_irq;
    logic [1:0] rx_cnt;
    logic       rd_valid;
    logic [7:0] err_word;
    logic [8:0] remaining;
  } res_t;

  typedef struct packed {
    logic tx_wr;
    logic tx_rd_zero;
  } memctl_t;

endpackage

>>> hdl/i2c_master_transfer_sequencer_core.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer core
// Turns controller events into data register writes and control actions
// for one interrupt-driven I2C master transfer.
// ----------------------------------------------------------------------------
// Every accepted item (a transmit byte load, a transfer start, a controller
// event, an error event or a status read) gives exactly one result item,
// which is registered in the working stage and then in the output register
// before it is offered. The transmit and receive buffers are synchronous
// memories of BUFFER_DEPTH bytes with one write port and one read port each;
// a buffer position wraps modulo BUFFER_DEPTH. The block takes one item per
// cycle while the output is not stalled, except that an event which stores
// two received bytes holds the receive memory's single write port for its
// second byte too, so the item after it waits until that byte is written.
// A result waiting at the output does not stop the next item from entering:
// one working stage and the output register sit between the two sides.
// Buffer entries never loaded read back as undefined data.
module i2c_master_transfer_sequencer_core #(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // From bit 0: buffer_index[7:0], data_byte[15:8], second_byte[23:16],
  // slave_address[31:24], byte_count[40:32], direction[41], flags[48:42].
  input  logic [55:0] s_axis_tdata,
  // command[2:0].
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // From bit 0: dr_write_valid[0], dr_write_data[8:1], start_request[9],
  // stop_request[10], ack_action[12:11], pos_set[13], buf_irq_action[15:14],
  // evt_irq_action[17:16], rx_stored_count[19:18], read_data[27:20],
  // error_word[35:28], remaining_count[44:36].
  output logic [47:0] m_axis_tdata
);

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  // Position-to-slot table: an 8-bit position modulo the buffer depth.
  logic [AW-1:0] slot_lut [256];
  for (genvar g = 0; g < 256; g++) begin : g_slot
    assign slot_lut[g] = AW'(g % BUFFER_DEPTH);
  end

  // Input unpacking.
  i2cts_pkg::cmd_e cmd;
  logic [7:0]      buffer_index;
  logic [7:0]      data_byte;
  logic [7:0]      second_byte;
  logic [7:0]      slave_address;
  logic [8:0]      byte_count;
  logic            direction;
  logic [6:0]      flags;

  assign cmd           = i2cts_pkg::cmd_e'(s_axis_tuser);
  assign buffer_index  = s_axis_tdata[7:0];
  assign data_byte     = s_axis_tdata[15:8];
  assign second_byte   = s_axis_tdata[23:16];
  assign slave_address = s_axis_tdata[31:24];
  assign byte_count    = s_axis_tdata[40:32];
  assign direction     = s_axis_tdata[41];
  assign flags         = s_axis_tdata[48:42];

  // Control state and decision logic.
  i2cts_pkg::state_t  state_q, state_d;
  i2cts_pkg::res_t    res;
  i2cts_pkg::memctl_t mc;

  i2cts_ctrl u_ctrl (
    .cmd_i          (cmd),
    .slave_address_i(slave_address),
    .byte_count_i   (byte_count),
    .direction_i    (direction),
    .flags_i        (flags),
    .cur_i          (state_q),
    .nxt_o          (state_d),
    .res_o          (res),
    .mc_o           (mc)
  );

  // Handshake and pipeline control.
  logic acc;
  logic out_free;
  logic s1_adv;
  logic s1_valid_q;
  logic out_valid_q;
  logic pend_valid_q;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !pend_valid_q && (!s1_valid_q || out_free);
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Memory addresses.
  logic [AW-1:0] idx_slot;
  logic [AW-1:0] tx_rd_addr;
  logic [AW-1:0] rx_wr_addr;
  logic [AW-1:0] rx_wr_addr2;
  logic [7:0]    rx_pos_inc;

  assign rx_pos_inc  = state_q.rx_pos + 8'd1;
  assign idx_slot    = slot_lut[buffer_index];
  assign tx_rd_addr  = mc.tx_rd_zero ? '0 : slot_lut[state_q.tx_pos];
  assign rx_wr_addr  = slot_lut[state_q.rx_pos];
  assign rx_wr_addr2 = slot_lut[rx_pos_inc];

  // Transmit buffer: written by loads, read for each item as it enters.
  logic [7:0] tx_mem [BUFFER_DEPTH];
  logic [7:0] tx_rdata_q;

  always_ff @(posedge clk_i) begin
    if (acc && mc.tx_wr) begin
      tx_mem[idx_slot] <= data_byte;
    end
    if (acc) begin
      tx_rdata_q <= tx_mem[tx_rd_addr];
    end
  end

  // Receive buffer: the second byte of a two-byte store is held in a pending
  // register and written while the input is stalled.
  logic [7:0]    rx_mem [BUFFER_DEPTH];
  logic [7:0]    rx_rdata_q;
  logic [AW-1:0] pend_addr_q;
  logic [7:0]    pend_data_q;

  always_ff @(posedge clk_i) begin
    if (pend_valid_q) begin
      rx_mem[pend_addr_q] <= pend_data_q;
    end else if (acc && (res.rx_cnt != 2'd0)) begin
      rx_mem[rx_wr_addr] <= data_byte;
    end
    if (acc) begin
      rx_rdata_q <= rx_mem[idx_slot];
    end
    if (acc && (res.rx_cnt == 2'd2)) begin
      pend_addr_q <= rx_wr_addr2;
      pend_data_q <= second_byte;
    end
  end

  // Working stage and output register payload.
  i2cts_pkg::res_t s1_res_q;
  logic [7:0]      s1_taddr_q;
  logic [47:0]     out_q;
  logic [47:0]     out_d;
  logic [7:0]      drd;
  logic [7:0]      rd;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_res_q   <= res;
      s1_taddr_q <= state_q.target_addr;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign drd = !s1_res_q.drv ? 8'd0 :
               (s1_res_q.drd_from_addr ? s1_taddr_q : tx_rdata_q);
  assign rd  = s1_res_q.rd_valid ? rx_rdata_q : 8'd0;

  assign out_d = {3'b000,
                  s1_res_q.remaining,
                  s1_res_q.err_word,
                  rd,
                  s1_res_q.rx_cnt,
                  2'(s1_res_q.evt_irq),
                  2'(s1_res_q.buf_irq),
                  s1_res_q.pos,
                  2'(s1_res_q.ack),
                  s1_res_q.stop,
                  s1_res_q.start,
                  drd,
                  s1_res_q.drv};

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        state_q <= state_d;
      end
      pend_valid_q <= acc && (res.rx_cnt == 2'd2);
      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // The pending second receive byte owns the write port: no item may enter.
  a_pend_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> !s_axis_tready)
    else $error("item accepted while a receive byte write is pending");

  // A two-byte store always leaves its second byte pending in the next cycle, with input stalled.
  a_two_byte_pends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (res.rx_cnt == 2'd2)) |=> (pend_valid_q && !s_axis_tready))
    else $error("second received byte was not queued");

  // A stalled working stage keeps its item.
  a_s1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_res_q)))
    else $error("working stage item lost under back-pressure");

  // The byte counter never exceeds a full transfer.
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bytes_left <= i2cts_pkg::MAX_COUNT)
    else $error("remaining byte count out of range");

endmodule

>>> hdl/i2cts_ctrl.sv
// ----------------------------------------------------------------------------
// I2C transfer sequencer decision logic
// Decodes one command against the current control state and gives the next
// state, the result fields and the memory controls.
// ----------------------------------------------------------------------------
module i2cts_ctrl (
  input  i2cts_pkg::cmd_e    cmd_i,
  input  logic [7:0]         slave_address_i,
  input  logic [8:0]         byte_count_i,
  input  logic               direction_i,
  input  logic [6:0]         flags_i,
  input  i2cts_pkg::state_t  cur_i,
  output i2cts_pkg::state_t  nxt_o,
  output i2cts_pkg::res_t    res_o,
  output i2cts_pkg::memctl_t mc_o
);

  logic [8:0] bl_dec;
  logic [8:0] cnt_sat;

  assign bl_dec  = (cur_i.bytes_left == 9'd0) ? 9'd0 : cur_i.bytes_left - 9'd1;
  assign cnt_sat = (byte_count_i > i2cts_pkg::MAX_COUNT) ? i2cts_pkg::MAX_COUNT
                                                         : byte_count_i;

  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    mc_o  = '0;
    case (cmd_i)
      i2cts_pkg::CMD_LOAD: begin
        mc_o.tx_wr = 1'b1;
      end
      i2cts_pkg::CMD_START: begin
        nxt_o.receiving   = direction_i;
        nxt_o.target_addr = {slave_address_i[7:1], direction_i};
        nxt_o.bytes_left  = cnt_sat;
        res_o.start       = 1'b1;
        res_o.ack         = i2cts_pkg::ACT_ON;
        res_o.evt_irq     = i2cts_pkg::ACT_ON;
        if (direction_i && (cnt_sat == 9'd2)) begin
          res_o.buf_irq = i2cts_pkg::ACT_OFF;
          res_o.pos     = 1'b1;
        end else begin
          res_o.buf_irq = i2cts_pkg::ACT_ON;
        end
      end
      i2cts_pkg::CMD_EVENT: begin
        if (!flags_i[i2cts_pkg::FLG_MASTER]) begin
          nxt_o.err_bits = i2cts_pkg::ERR_NOT_MASTER;
          res_o.buf_irq  = i2cts_pkg::ACT_OFF;
          res_o.evt_irq  = i2cts_pkg::ACT_OFF;
        end else if (flags_i[i2cts_pkg::FLG_SB]) begin
          res_o.drv           = 1'b1;
          res_o.drd_from_addr = 1'b1;
        end else if (flags_i[i2cts_pkg::FLG_ADDR]) begin
          if (!cur_i.receiving) begin
            // First transmit byte comes from the start of the buffer.
            mc_o.tx_rd_zero  = 1'b1;
            res_o.drv        = 1'b1;
            nxt_o.tx_pos     = 8'd1;
            nxt_o.bytes_left = bl_dec;
            if (bl_dec == 9'd0) begin
              res_o.buf_irq = i2cts_pkg::ACT_OFF;
            end
          end else begin
            nxt_o.rx_pos = 8'd0;
            if (cur_i.bytes_left == 9'd1) begin
              res_o.ack  = i2cts_pkg::ACT_OFF;
              res_o.stop = 1'b1;
            end else if (cur_i.bytes_left == 9'd2) begin
              res_o.ack = i2cts_pkg::ACT_OFF;
            end
          end
        end else if (flags_i[i2cts_pkg::FLG_TXE]) begin
          if (!flags_i[i2cts_pkg::FLG_BTF]) begin
            if (cur_i.bytes_left != 9'd0) begin
              res_o.drv        = 1'b1;
              nxt_o.tx_pos     = cur_i.tx_pos + 8'd1;
              nxt_o.bytes_left = bl_dec;
              if (bl_dec == 9'd0) begin
                res_o.buf_irq = i2cts_pkg::ACT_OFF;
              end
            end
          end else begin
            res_o.stop    = 1'b1;
            res_o.evt_irq = i2cts_pkg::ACT_OFF;
          end
        end else if (flags_i[i2cts_pkg::FLG_RXNE]) begin
          if (cur_i.bytes_left == 9'd3) begin
            res_o.buf_irq = i2cts_pkg::ACT_OFF;
          end
          if (flags_i[i2cts_pkg::FLG_BTF]) begin
            if (cur_i.bytes_left == 9'd2) begin
              // Two-byte end: both data register reads are stored.
              res_o.stop       = 1'b1;
              res_o.rx_cnt     = 2'd2;
              nxt_o.rx_pos     = cur_i.rx_pos + 8'd2;
              nxt_o.bytes_left = 9'd0;
            end else begin
              if (cur_i.bytes_left == 9'd3) begin
                res_o.ack = i2cts_pkg::ACT_OFF;
              end
              res_o.rx_cnt     = 2'd1;
              nxt_o.rx_pos     = cur_i.rx_pos + 8'd1;
              nxt_o.bytes_left = bl_dec;
            end
          end else if (cur_i.bytes_left != 9'd3) begin
            res_o.rx_cnt     = 2'd1;
            nxt_o.rx_pos     = cur_i.rx_pos + 8'd1;
            nxt_o.bytes_left = bl_dec;
          end
        end
      end
      i2cts_pkg::CMD_ERROR: begin
        nxt_o.err_bits = cur_i.err_bits | {1'b0, flags_i};
        res_o.buf_irq  = i2cts_pkg::ACT_OFF;
        res_o.evt_irq  = i2cts_pkg::ACT_OFF;
      end
      i2cts_pkg::CMD_STATUS: begin
        res_o.rd_valid = 1'b1;
        nxt_o.err_bits = 8'd0;
      end
      default: begin
      end
    endcase
    res_o.err_word  = (cmd_i == i2cts_pkg::CMD_STATUS) ? cur_i.err_bits : nxt_o.err_bits;
    res_o.remaining = nxt_o.bytes_left;
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer testbench
// Drives load, start, event, error and status items into the core and
// checks every result item against a cycle-free behavioral predictor.
// ----------------------------------------------------------------------------
// Stimulus starts with a short directed pass over the corner cases: address
// send on SB, transmit feed and STOP on TXE/BTF, the one-, two- and
// three-byte reception endings, an event without the master flag, error
// accumulation, count saturation and an exhausted count. After that, random
// transfers follow: well-formed write and read sequences with random data and
// lengths, sprinkled with random noise items, status reads and aborts. The
// sender works in bursts with random gaps; the receiver stalls on a pattern
// that changes mode at random intervals, including a mode with no
// stalls. Store entries that were never written are never read: a missing
// transmit byte is loaded just before the event that would send it, and
// status reads only address receive entries that already hold a byte.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 256;
  localparam int          ITEM_TARGET  = 1400;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          MAX_REPORTS  = 10;

  // Event flag masks built from the package bit positions.
  localparam logic [6:0] EV_SB     = 7'd1 << i2cts_pkg::FLG_SB;
  localparam logic [6:0] EV_ADDR   = 7'd1 << i2cts_pkg::FLG_ADDR;
  localparam logic [6:0] EV_BTF    = 7'd1 << i2cts_pkg::FLG_BTF;
  localparam logic [6:0] EV_TXE    = 7'd1 << i2cts_pkg::FLG_TXE;
  localparam logic [6:0] EV_RXNE   = 7'd1 << i2cts_pkg::FLG_RXNE;
  localparam logic [6:0] EV_MASTER = 7'd1 << i2cts_pkg::FLG_MASTER;
  localparam logic [6:0] EV_SPARE  = 7'h40;
  localparam logic [6:0] ALL_FLAGS = 7'h7F;

  // The highest command code; codes above CMD_STATUS are ignored by the core.
  localparam logic [2:0] CMD_UNUSED_TOP = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [6:0] flags;
    logic       dir;
    logic [8:0] cnt;
    logic [7:0] addr;
    logic [7:0] d2;
    logic [7:0] d1;
    logic [7:0] idx;
  } xfer_item_t;

  // Laid out so that bit 0 of the struct is bit 0 of the result tdata.
  typedef struct packed {
    logic [8:0] rem;
    logic [7:0] err;
    logic [7:0] rd;
    logic [1:0] rxc;
    logic [1:0] evt_irq;
    logic [1:0] buf_irq;
    logic       pos;
    logic [1:0] ack;
    logic       stop;
    logic       start;
    logic [7:0] drd;
    logic       drv;
  } seq_result_t;

  // Behavioral copy of the sequencer plus the queue of responses it predicts.
  class transfer_scoreboard;
    logic [7:0]  tx_bytes [DEPTH];
    logic [7:0]  rx_bytes [DEPTH];
    bit          tx_valid [DEPTH];
    bit          rx_valid [DEPTH];
    logic [7:0]  tx_pos;
    logic [7:0]  rx_pos;
    logic [8:0]  bytes_left;
    logic        receiving;
    logic [7:0]  target;
    logic [7:0]  err_bits;
    seq_result_t expected_responses[$];
    int          mismatches;
    int          checked;

    function new();
      tx_pos     = '0;
      rx_pos     = '0;
      bytes_left = '0;
      receiving  = 1'b0;
      target     = '0;
      err_bits   = '0;
      mismatches = 0;
      checked    = 0;
      foreach (tx_valid[i]) begin
        tx_valid[i] = 1'b0;
        rx_valid[i] = 1'b0;
      end
    endfunction

    function int outstanding();
      return expected_responses.size();
    endfunction

    // Index of the transmit entry this item would send, or -1 if none.
    function int tx_read_index(xfer_item_t it);
      if (it.cmd != i2cts_pkg::CMD_EVENT || !it.flags[i2cts_pkg::FLG_MASTER]) return -1;
      if (it.flags[i2cts_pkg::FLG_SB]) return -1;
      if (it.flags[i2cts_pkg::FLG_ADDR]) return receiving ? -1 : 0;
      if (it.flags[i2cts_pkg::FLG_TXE] && !it.flags[i2cts_pkg::FLG_BTF] && bytes_left != 0)
        return int'(tx_pos);
      return -1;
    endfunction

    // Points a status read at a receive entry that holds a byte; with none
    // written yet, the item becomes a transmit load instead.
    function xfer_item_t legalize(xfer_item_t it);
      int k;
      if (it.cmd != i2cts_pkg::CMD_STATUS) return it;
      for (k = 0; k < DEPTH; k++) begin
        if (rx_valid[8'(it.idx + 8'(k))]) begin
          it.idx = 8'(it.idx + 8'(k));
          return it;
        end
      end
      it.cmd = i2cts_pkg::CMD_LOAD;
      return it;
    endfunction

    function void count_down();
      if (bytes_left != 0) bytes_left--;
    endfunction

    function void send_tx(ref seq_result_t r);
      r.drv = 1'b1;
      r.drd = tx_bytes[tx_pos];
      tx_pos++;
      count_down();
      if (bytes_left == 0) r.buf_irq = i2cts_pkg::ACT_OFF;
    endfunction

    function void keep_rx(logic [7:0] b, ref seq_result_t r);
      rx_bytes[rx_pos] = b;
      rx_valid[rx_pos] = 1'b1;
      rx_pos++;
      count_down();
      r.rxc++;
    endfunction

    function void apply_event(xfer_item_t it, ref seq_result_t r);
      // Losing master status overwrites the error word and stops everything.
      if (!it.flags[i2cts_pkg::FLG_MASTER]) begin
        err_bits  = i2cts_pkg::ERR_NOT_MASTER;
        r.buf_irq = i2cts_pkg::ACT_OFF;
        r.evt_irq = i2cts_pkg::ACT_OFF;
        return;
      end
      if (it.flags[i2cts_pkg::FLG_SB]) begin
        r.drv = 1'b1;
        r.drd = target;
        return;
      end
      if (it.flags[i2cts_pkg::FLG_ADDR]) begin
        if (!receiving) begin
          tx_pos = '0;
          send_tx(r);
        end else begin
          rx_pos = '0;
          if (bytes_left == 1) begin
            r.ack  = i2cts_pkg::ACT_OFF;
            r.stop = 1'b1;
          end else if (bytes_left == 2) begin
            r.ack = i2cts_pkg::ACT_OFF;
          end
        end
        return;
      end
      if (it.flags[i2cts_pkg::FLG_TXE]) begin
        if (!it.flags[i2cts_pkg::FLG_BTF]) begin
          if (bytes_left != 0) send_tx(r);
        end else begin
          r.stop    = 1'b1;
          r.evt_irq = i2cts_pkg::ACT_OFF;
        end
        return;
      end
      if (it.flags[i2cts_pkg::FLG_RXNE]) begin
        if (bytes_left == 3) r.buf_irq = i2cts_pkg::ACT_OFF;
        if (it.flags[i2cts_pkg::FLG_BTF]) begin
          // Two bytes left: both data register reads are stored under STOP.
          if (bytes_left == 2) begin
            r.stop = 1'b1;
            keep_rx(it.d1, r);
            keep_rx(it.d2, r);
          end else begin
            if (bytes_left == 3) r.ack = i2cts_pkg::ACT_OFF;
            keep_rx(it.d1, r);
          end
        end else if (bytes_left != 3) begin
          keep_rx(it.d1, r);
        end
      end
    endfunction

    function void accept_item(xfer_item_t it);
      seq_result_t r;
      bit          err_reported;
      r            = '0;
      err_reported = 1'b0;
      case (it.cmd)
        i2cts_pkg::CMD_LOAD: begin
          tx_bytes[it.idx] = it.d1;
          tx_valid[it.idx] = 1'b1;
        end
        i2cts_pkg::CMD_START: begin
          receiving  = it.dir;
          target     = it.dir ? (it.addr | 8'h01) : (it.addr & 8'hFE);
          bytes_left = (it.cnt > i2cts_pkg::MAX_COUNT) ? i2cts_pkg::MAX_COUNT : it.cnt;
          r.start    = 1'b1;
          r.ack      = i2cts_pkg::ACT_ON;
          r.evt_irq  = i2cts_pkg::ACT_ON;
          if (it.dir && bytes_left == 2) begin
            r.buf_irq = i2cts_pkg::ACT_OFF;
            r.pos     = 1'b1;
          end else begin
            r.buf_irq = i2cts_pkg::ACT_ON;
          end
        end
        i2cts_pkg::CMD_EVENT: apply_event(it, r);
        i2cts_pkg::CMD_ERROR: begin
          err_bits  = err_bits | {1'b0, it.flags};
          r.buf_irq = i2cts_pkg::ACT_OFF;
          r.evt_irq = i2cts_pkg::ACT_OFF;
        end
        i2cts_pkg::CMD_STATUS: begin
          r.rd         = rx_bytes[it.idx];
          r.err        = err_bits;
          err_bits     = '0;
          err_reported = 1'b1;
        end
        default: ;
      endcase
      if (!err_reported) r.err = err_bits;
      r.rem = bytes_left;
      expected_responses.push_back(r);
    endfunction

    function void check_result(seq_result_t got);
      seq_result_t want;
      string       bad;
      bad = "";
      if (expected_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: result %p arrived with nothing expected", got);
        return;
      end
      want = expected_responses.pop_front();
      checked++;
      if (got.drv     != want.drv)     bad = {bad, " dr_write_valid"};
      if (got.drd     != want.drd)     bad = {bad, " dr_write_data"};
      if (got.start   != want.start)   bad = {bad, " start_request"};
      if (got.stop    != want.stop)    bad = {bad, " stop_request"};
      if (got.ack     != want.ack)     bad = {bad, " ack_action"};
      if (got.pos     != want.pos)     bad = {bad, " pos_set"};
      if (got.buf_irq != want.buf_irq) bad = {bad, " buf_irq_action"};
      if (got.evt_irq != want.evt_irq) bad = {bad, " evt_irq_action"};
      if (got.rxc     != want.rxc)     bad = {bad, " rx_stored_count"};
      if (got.rd      != want.rd)      bad = {bad, " read_data"};
      if (got.err     != want.err)     bad = {bad, " error_word"};
      if (got.rem     != want.rem)     bad = {bad, " remaining_count"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: mismatch in%s: expected %p, got %p", bad, want, got);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;   // item fields, buffer_index in the lowest bits
  logic [2:0]  s_axis_tuser  = '0;   // command[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // result fields, dr_write_valid in bit 0

  transfer_scoreboard sb = new();

  int quiet_cycles = 0;
  int items_done   = 0;
  int transfers    = 0;
  int burst_left   = 0;
  int cmd_tally[8];
  int stall_mode   = 0;
  int stall_tick   = 0;
  int stall_phase  = 0;

  i2c_master_transfer_sequencer_core #(
    .BUFFER_DEPTH(DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver back-pressure: the mode switches at random intervals
  // between always ready, coin flips, a fixed repeating on/off rhythm and
  // mostly stalled.
  always @(negedge clk_i) begin
    if (stall_tick == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_tick = $urandom_range(100, 400);
    end else begin
      stall_tick--;
    end
    stall_phase = (stall_phase + 1) % 5;
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (stall_phase < 3);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Result monitor and the no-progress counter used by the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(seq_result_t'(m_axis_tdata[44:0]));
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: no handshake for %0d cycles", QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  function automatic xfer_item_t rand_item(logic [2:0] cmd);
    xfer_item_t it;
    it.cmd   = cmd;
    it.idx   = 8'($urandom);
    it.d1    = 8'($urandom);
    it.d2    = 8'($urandom);
    it.addr  = 8'($urandom);
    it.cnt   = 9'($urandom);
    it.dir   = 1'($urandom);
    it.flags = 7'($urandom);
    return it;
  endfunction

  function automatic xfer_item_t mk(logic [2:0] cmd, logic [7:0] idx, logic [7:0] d1,
                                    logic [7:0] d2, logic [7:0] addr, logic [8:0] cnt,
                                    logic dir, logic [6:0] flags);
    xfer_item_t it;
    it = '{cmd: cmd, flags: flags, dir: dir, cnt: cnt, addr: addr, d2: d2, d1: d1,
           idx: idx};
    return it;
  endfunction

  // A controller event with random data; the extra mask only holds flags
  // that rank below the ones in base, so the acted-on flag does not change.
  function automatic xfer_item_t ctrl_event(logic [6:0] base, logic [6:0] extra);
    xfer_item_t it;
    it       = rand_item(i2cts_pkg::CMD_EVENT);
    it.flags = base | EV_MASTER | (7'($urandom) & extra);
    return it;
  endfunction

  function automatic int pick_count();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8)  return 0;
    if (p < 72) return $urandom_range(1, 6);
    if (p < 97) return $urandom_range(7, 24);
    if (p < 98) return $urandom_range(25, 255);
    if (p < 99) return 256;
    return $urandom_range(257, 511);
  endfunction

  task automatic drive_item(xfer_item_t it);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, it.flags, it.dir, it.cnt, it.addr, it.d2, it.d1, it.idx};
    s_axis_tuser  <= it.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.accept_item(it);
    cmd_tally[it.cmd]++;
    if (it.cmd <= i2cts_pkg::CMD_STATUS) items_done++;
    // Burst bookkeeping: at the end of a burst the sender drops valid for a
    // random gap; long bursts give stretches without any input gaps.
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // Sends one item after making it legal: status reads are steered to
  // stored bytes, and a transmit byte that was never loaded is loaded first.
  task automatic push_item(xfer_item_t it);
    xfer_item_t legal;
    int         need;
    legal = sb.legalize(it);
    need  = sb.tx_read_index(legal);
    if (need >= 0 && !sb.tx_valid[need])
      drive_item(mk(i2cts_pkg::CMD_LOAD, 8'(need), 8'($urandom), 8'($urandom),
                    8'($urandom), 9'($urandom), 1'($urandom), 7'($urandom)));
    drive_item(legal);
  endtask

  task automatic run_directed();
    xfer_item_t seq_items[$];
    seq_items = '{
      mk(i2cts_pkg::CMD_LOAD, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0, '0),
      mk(i2cts_pkg::CMD_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'h1FF, 1'b1, ALL_FLAGS),
      mk(i2cts_pkg::CMD_LOAD, 8'h01, 8'hA5, 8'h00, 8'h00, 9'd0, 1'b0, '0),
      mk(CMD_UNUSED_TOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'h1FF, 1'b1, ALL_FLAGS),
      // Two-byte write; every flag set at once must act on SB only.
      mk(i2cts_pkg::CMD_START, 8'h00, 8'h00, 8'h00, 8'hFF, 9'd2, 1'b0, '0),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0, ALL_FLAGS),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0,
         EV_MASTER | EV_ADDR | EV_TXE),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0, EV_MASTER | EV_TXE),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0, EV_MASTER | EV_TXE),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0,
         EV_MASTER | EV_TXE | EV_BTF),
      // Lost master, then every error kind on top of it.
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0,
         ALL_FLAGS & ~EV_MASTER),
      mk(i2cts_pkg::CMD_ERROR, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0, ALL_FLAGS),
      // Two-byte read with POS, then a status read that clears the errors.
      mk(i2cts_pkg::CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 9'd2, 1'b1, '0),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0, EV_MASTER | EV_SB),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0, EV_MASTER | EV_ADDR),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h11, 8'h22, 8'h00, 9'd0, 1'b0,
         EV_MASTER | EV_RXNE | EV_BTF),
      mk(i2cts_pkg::CMD_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0, '0),
      // Three-byte read ending: RXNE at three left only drops the buffer IRQ.
      mk(i2cts_pkg::CMD_START, 8'h00, 8'h00, 8'h00, 8'h5A, 9'd3, 1'b1, '0),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0, EV_MASTER | EV_ADDR),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h33, 8'h00, 8'h00, 9'd0, 1'b0, EV_MASTER | EV_RXNE),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h44, 8'h00, 8'h00, 9'd0, 1'b0,
         EV_MASTER | EV_RXNE | EV_BTF),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h55, 8'h66, 8'h00, 9'd0, 1'b0,
         EV_MASTER | EV_RXNE | EV_BTF),
      // Oversized count saturates; one-byte read, then a byte past the count.
      mk(i2cts_pkg::CMD_START, 8'h00, 8'h00, 8'h00, 8'h80, 9'h1FF, 1'b0, '0),
      mk(i2cts_pkg::CMD_START, 8'h00, 8'h00, 8'h00, 8'h81, 9'd1, 1'b1, '0),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0, EV_MASTER | EV_ADDR),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h77, 8'h00, 8'h00, 9'd0, 1'b0, EV_MASTER | EV_RXNE),
      mk(i2cts_pkg::CMD_EVENT, 8'h00, 8'h88, 8'h00, 8'h00, 9'd0, 1'b0, EV_MASTER | EV_RXNE),
      mk(i2cts_pkg::CMD_STATUS, 8'h01, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0, '0)
    };
    foreach (seq_items[i]) push_item(seq_items[i]);
  endtask

  // One random transfer: optional transmit loads, START, SB, ADDR and then
  // the data phase that a driver would run, with noise mixed in.
  task automatic run_transfer();
    xfer_item_t plan[$];
    xfer_item_t it;
    int         n;
    int         eff;
    int         k;
    int         cut;
    logic       rd;
    rd  = 1'($urandom);
    n   = pick_count();
    eff = (n > DEPTH) ? DEPTH : n;
    if (!rd) begin
      k = $urandom_range(0, (eff < 24) ? eff : 24);
      for (int i = 0; i < k; i++) begin
        it     = rand_item(i2cts_pkg::CMD_LOAD);
        it.idx = 8'(i);
        plan.push_back(it);
      end
    end
    it     = rand_item(i2cts_pkg::CMD_START);
    it.cnt = 9'(n);
    it.dir = rd;
    plan.push_back(it);
    plan.push_back(ctrl_event(EV_SB, EV_ADDR | EV_BTF | EV_TXE | EV_RXNE | EV_SPARE));
    plan.push_back(ctrl_event(EV_ADDR, EV_BTF | EV_TXE | EV_RXNE | EV_SPARE));
    if (!rd) begin
      for (int i = 1; i < eff; i++) plan.push_back(ctrl_event(EV_TXE, EV_RXNE | EV_SPARE));
      if (eff == 0 || $urandom_range(0, 7) == 0)
        plan.push_back(ctrl_event(EV_TXE, EV_RXNE | EV_SPARE));
      plan.push_back(ctrl_event(EV_TXE | EV_BTF, EV_RXNE | EV_SPARE));
    end else if (eff <= 2) begin
      if (eff == 2) plan.push_back(ctrl_event(EV_RXNE | EV_BTF, EV_SPARE));
      else          plan.push_back(ctrl_event(EV_RXNE, EV_SPARE));
    end else begin
      for (int i = 0; i < eff - 3; i++) plan.push_back(ctrl_event(EV_RXNE, EV_SPARE));
      if ($urandom_range(0, 1) == 1) plan.push_back(ctrl_event(EV_RXNE, EV_SPARE));
      plan.push_back(ctrl_event(EV_RXNE | EV_BTF, EV_SPARE));
      plan.push_back(ctrl_event(EV_RXNE | EV_BTF, EV_SPARE));
    end
    if ($urandom_range(0, 2) == 0) plan.push_back(rand_item(i2cts_pkg::CMD_STATUS));
    // Long transfers are mostly cut short; short ones now and then.
    cut = -1;
    if ((eff > 24 && $urandom_range(0, 1) == 0) || $urandom_range(0, 9) == 0)
      cut = $urandom_range(1, (plan.size() < 40) ? plan.size() : 40);
    foreach (plan[i]) begin
      if (i == cut) break;
      if ($urandom_range(0, 99) < 8) push_item(rand_item(3'($urandom_range(0, 7))));
      if ($urandom_range(0, 99) < 4) push_item(rand_item(i2cts_pkg::CMD_STATUS));
      push_item(plan[i]);
    end
    transfers++;
  endtask

  initial begin
    foreach (cmd_tally[i]) cmd_tally[i] = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    while (items_done < ITEM_TARGET) run_transfer();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d items: %0d loads, %0d starts, %0d events, %0d errors, %0d status reads",
             items_done, cmd_tally[i2cts_pkg::CMD_LOAD], cmd_tally[i2cts_pkg::CMD_START],
             cmd_tally[i2cts_pkg::CMD_EVENT], cmd_tally[i2cts_pkg::CMD_ERROR],
             cmd_tally[i2cts_pkg::CMD_STATUS]);
    $display("tb: %0d ignored codes, %0d random transfers, %0d results checked, %0d bad",
             cmd_tally[5] + cmd_tally[6] + cmd_tally[CMD_UNUSED_TOP], transfers, sb.checked,
             sb.mismatches);
    if (sb.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
